// File: rtl/billboard_sprite_projection_assert.svh
// ----------------------------------------------------------------------------
// billboard_sprite_projection assertion macros
// Shared assertion wrappers. Each one samples on clk and is off during reset.
// ----------------------------------------------------------------------------
`ifndef BILLBOARD_SPRITE_PROJECTION_ASSERT_SVH
`define BILLBOARD_SPRITE_PROJECTION_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Flag a condition that must never be seen outside reset.
`define BSP_ASSERT_NEVER(lbl, cond, msg) \
    `BSP_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Widths, constants and register codes of the billboard sprite projector.
// ----------------------------------------------------------------------------
package bsp_pkg;

    // Position difference and CORDIC datapath widths
    localparam int DXY_W        = 33;
    localparam int CXY_W        = 36;
    localparam int Z_W          = 20;
    localparam int CORDIC_STEPS = 17;

    // Heading difference width (Q4.12 plus headroom)
    localparam int DIFF_W = 18;

    // Root extraction: one result bit per stage
    localparam int SQRT_STEPS = 32;

    // Divider widths: numerator/quotient and denominator
    localparam int QUO_W = 40;
    localparam int DEN_W = 33;

    localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [DIFF_W-1:0] PI_Q12     = 18'sd12868;
    localparam logic signed [DIFF_W-1:0] TWO_PI_Q12 = 18'sd25736;

    localparam logic signed [Z_W-1:0] CORDIC_ATAN [CORDIC_STEPS] = '{
        20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
        20'sd8, 20'sd4, 20'sd2, 20'sd1
    };

    // Configuration register indexes
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FIELD_OF_VIEW = 2'd2;

    localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd640;
    localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;
    localparam logic [14:0] FOV_RST           = 15'd4289;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic [30:0]        U31_MAX = 31'h7FFF_FFFF;

endpackage

// File: rtl/bsp_cordic.sv
// ----------------------------------------------------------------------------
// bsp_cordic
// Pipelined CORDIC vectoring: quarter-turn pre-rotation, then one micro
// rotation per stage. Returns the accumulated angle in Q.16.
// ----------------------------------------------------------------------------
module bsp_cordic #(
    parameter int TAG_W = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [bsp_pkg::DXY_W-1:0] in_x,
    input  logic signed [bsp_pkg::DXY_W-1:0] in_y,
    input  logic [TAG_W-1:0]                 in_tag,
    output logic                             out_valid,
    output logic signed [bsp_pkg::Z_W-1:0]   out_z,
    output logic [TAG_W-1:0]                 out_tag
);
    import bsp_pkg::*;

    logic signed [CXY_W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CXY_W-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]   z_reg [0:CORDIC_STEPS];
    logic [TAG_W-1:0]        tag_reg [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0]   v_reg;

    logic signed [CXY_W-1:0] pre_x;
    logic signed [CXY_W-1:0] pre_y;
    logic signed [Z_W-1:0]   pre_z;

    // Rotate into the right half plane
    always_comb
    begin
        if (in_x[DXY_W-1]) begin
            if (!in_y[DXY_W-1]) begin
                pre_x = CXY_W'(in_y);
                pre_y = -CXY_W'(in_x);
                pre_z = HALF_PI_Q16;
            end
            else begin
                pre_x = -CXY_W'(in_y);
                pre_y = CXY_W'(in_x);
                pre_z = -HALF_PI_Q16;
            end
        end
        else begin
            pre_x = CXY_W'(in_x);
            pre_y = CXY_W'(in_y);
            pre_z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else if (en) begin
            v_reg <= {v_reg[CORDIC_STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            x_reg[0]   <= pre_x;
            y_reg[0]   <= pre_y;
            z_reg[0]   <= pre_z;
            tag_reg[0] <= in_tag;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (!y_reg[i][CXY_W-1] && (y_reg[i] != '0)) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + CORDIC_ATAN[i];
                end
                else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - CORDIC_ATAN[i];
                end
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STEPS];
    assign out_z     = z_reg[CORDIC_STEPS];
    assign out_tag   = tag_reg[CORDIC_STEPS];

endmodule

// File: rtl/bsp_div.sv
// ----------------------------------------------------------------------------
// bsp_div
// Pipelined restoring divider, several lanes side by side, one quotient bit
// per stage. The numerator must fit the quotient width.
// ----------------------------------------------------------------------------
module bsp_div #(
    parameter int LANES = 2,
    parameter int NUM_W = 8,
    parameter int DEN_W = 8,
    parameter int TAG_W = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]     in_num,
    input  logic [LANES-1:0][DEN_W-1:0]     in_den,
    input  logic [TAG_W-1:0]                in_tag,
    output logic                            out_valid,
    output logic [LANES-1:0][NUM_W-1:0]     out_quo,
    output logic [TAG_W-1:0]                out_tag
);

    logic [LANES-1:0][NUM_W-1:0] nq_reg  [0:NUM_W-1];
    logic [LANES-1:0][DEN_W-1:0] rem_reg [0:NUM_W-2];
    logic [LANES-1:0][DEN_W-1:0] den_reg [0:NUM_W-2];
    logic [TAG_W-1:0]            tag_reg [0:NUM_W-1];
    logic [NUM_W-1:0]            v_reg;

    // Shift in the next numerator bit, subtract when it fits
    function automatic logic [DEN_W+NUM_W-1:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic [NUM_W-1:0] nq,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           q;
        trial = {rem, nq[NUM_W-1]};
        diff  = trial - {1'b0, den};
        q     = (trial >= {1'b0, den});
        return {q ? diff[DEN_W-1:0] : trial[DEN_W-1:0], nq[NUM_W-2:0], q};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else if (en) begin
            v_reg <= {v_reg[NUM_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            tag_reg[0] <= in_tag;
            for (int l = 0; l < LANES; l++) begin
                {rem_reg[0][l], nq_reg[0][l]} <= div_step('0, in_num[l], in_den[l]);
                den_reg[0][l] <= in_den[l];
            end
            for (int s = 1; s < NUM_W - 1; s++) begin
                tag_reg[s] <= tag_reg[s-1];
                for (int l = 0; l < LANES; l++) begin
                    {rem_reg[s][l], nq_reg[s][l]} <=
                        div_step(rem_reg[s-1][l], nq_reg[s-1][l], den_reg[s-1][l]);
                    den_reg[s][l] <= den_reg[s-1][l];
                end
            end
            tag_reg[NUM_W-1] <= tag_reg[NUM_W-2];
            for (int l = 0; l < LANES; l++) begin
                nq_reg[NUM_W-1][l] <= NUM_W'(div_step(rem_reg[NUM_W-2][l],
                                                      nq_reg[NUM_W-2][l],
                                                      den_reg[NUM_W-2][l]));
            end
        end
    end

    assign out_valid = v_reg[NUM_W-1];
    assign out_quo   = nq_reg[NUM_W-1];
    assign out_tag   = tag_reg[NUM_W-1];

endmodule

// File: rtl/billboard_sprite_projection.sv
// ----------------------------------------------------------------------------
// billboard_sprite_projection
// Projects one billboard sprite per beat onto the screen: bearing by CORDIC,
// heading wrap and field-of-view test, distance by root extraction, and the
// centered draw rectangle by pipelined division.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | sprite_x/y, cam_x/y, cam_angle, sizes
//   out     | out_valid / out_ready| visible, rect_left/top/w/h
//   cfg     | cfg_we               | cfg_index, cfg_data
//
// One beat enters per cycle while the pipeline is not held; each beat passes the
// input register, 18 CORDIC stages, 3 setup stages, 32 root stages, one
// numerator stage, 40 divider stages and the output register.
// All stages advance together; when the output register holds a beat that is
// not taken, the whole pipeline holds and in_ready drops.
// Reset clears the stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`include "billboard_sprite_projection_assert.svh"

module billboard_sprite_projection (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] sprite_x,
    input  logic signed [31:0] sprite_y,
    input  logic signed [31:0] cam_x,
    input  logic signed [31:0] cam_y,
    input  logic signed [15:0] cam_angle,
    input  logic [11:0]        sprite_width,
    input  logic [11:0]        sprite_height,
    input  logic signed [15:0] lift_offset,
    // output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic               visible,
    output logic signed [31:0] rect_left,
    output logic signed [31:0] rect_top,
    output logic [30:0]        rect_w,
    output logic [30:0]        rect_h
);
    import bsp_pkg::*;

    // Sideband carried through the CORDIC stages
    typedef struct packed {
        logic signed [DXY_W-1:0] dx;
        logic signed [DXY_W-1:0] dy;
        logic signed [15:0]      hd;
        logic [11:0]             sw;
        logic [11:0]             sh;
        logic signed [15:0]      lift;
    } ctag_t;

    // Sideband carried through the root stages
    typedef struct packed {
        logic               vis;
        logic [QUO_W-1:0]   snum;
        logic [15:0]        sden;
        logic               shf;
        logic [11:0]        sw;
        logic [11:0]        sh;
        logic signed [15:0] lift;
    } stag_t;

    // Sideband carried through the divider
    typedef struct packed {
        logic vis;
        logic zero;
        logic lift_neg;
    } dtag_t;

    // Divider lanes
    localparam int LN_SX   = 0;
    localparam int LN_W    = 1;
    localparam int LN_H    = 2;
    localparam int LN_HW   = 3;
    localparam int LN_HH   = 4;
    localparam int LN_LIFT = 5;
    localparam int LANES   = 6;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [11:0] screen_width_reg;
    logic [11:0] screen_height_reg;
    logic [14:0] fov_reg;
    logic [14:0] fov_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            fov_reg           <= FOV_RST;
        end
        else if (cfg_we) begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[11:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[11:0];
                CFG_FIELD_OF_VIEW: fov_reg           <= cfg_data;
                default: ;
            endcase
        end
    end

    // A zero field of view behaves as the smallest step
    assign fov_eff = (fov_reg == '0) ? 15'd1 : fov_reg;

    // ------------------------------------------------------------------
    // Global advance: hold everything while the output beat waits
    // ------------------------------------------------------------------
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // Input register: position differences
    // ------------------------------------------------------------------
    logic  p0_valid_reg;
    ctag_t p0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p0_valid_reg <= 1'b0;
        end
        else if (en) begin
            p0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            p0_reg.dx   <= DXY_W'(sprite_x) - DXY_W'(cam_x);
            p0_reg.dy   <= DXY_W'(sprite_y) - DXY_W'(cam_y);
            p0_reg.hd   <= cam_angle;
            p0_reg.sw   <= sprite_width;
            p0_reg.sh   <= sprite_height;
            p0_reg.lift <= lift_offset;
        end
    end

    // ------------------------------------------------------------------
    // Bearing
    // ------------------------------------------------------------------
    logic                  c_valid;
    logic signed [Z_W-1:0] c_z;
    ctag_t                 c_tag;

    bsp_cordic #(
        .TAG_W ($bits(ctag_t))
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p0_valid_reg),
        .in_x      (p0_reg.dx),
        .in_y      (p0_reg.dy),
        .in_tag    (p0_reg),
        .out_valid (c_valid),
        .out_z     (c_z),
        .out_tag   (c_tag)
    );

    // ------------------------------------------------------------------
    // Stage d1: round bearing, wrap heading difference, magnitudes
    // ------------------------------------------------------------------
    logic signed [Z_W-1:0]    z_rnd;
    logic signed [15:0]       bearing;
    logic signed [DIFF_W-1:0] diff_raw;
    logic signed [DIFF_W-1:0] diff_wrap;
    logic [DXY_W-1:0]         ax_full;
    logic [DXY_W-1:0]         ay_full;
    logic                     big;

    always_comb
    begin
        z_rnd = c_z + 20'sd8;
        if ((c_tag.dx == '0) && (c_tag.dy == '0)) begin
            bearing = '0;
        end
        else begin
            bearing = z_rnd[Z_W-1:4];
        end
        diff_raw = DIFF_W'(bearing) - DIFF_W'(c_tag.hd);
        if (diff_raw < -PI_Q12) begin
            diff_wrap = diff_raw + TWO_PI_Q12;
        end
        else if (diff_raw > PI_Q12) begin
            diff_wrap = diff_raw - TWO_PI_Q12;
        end
        else begin
            diff_wrap = diff_raw;
        end
        ax_full = c_tag.dx[DXY_W-1] ? DXY_W'(-c_tag.dx) : DXY_W'(c_tag.dx);
        ay_full = c_tag.dy[DXY_W-1] ? DXY_W'(-c_tag.dy) : DXY_W'(c_tag.dy);
        big     = ax_full[32] | ax_full[31] | ay_full[32] | ay_full[31];
    end

    logic                     d1_valid_reg;
    logic signed [DIFF_W-1:0] d1_diff_reg;
    logic [30:0]              d1_ax_reg;
    logic [30:0]              d1_ay_reg;
    logic                     d1_shf_reg;
    logic [11:0]              d1_sw_reg;
    logic [11:0]              d1_sh_reg;
    logic signed [15:0]       d1_lift_reg;

    always_ff @(posedge clk)
    begin
        if (en) begin
            d1_diff_reg <= diff_wrap;
            // halve both legs when either reaches 2^31 so the squares fit
            d1_ax_reg   <= big ? ax_full[31:1] : ax_full[30:0];
            d1_ay_reg   <= big ? ay_full[31:1] : ay_full[30:0];
            d1_shf_reg  <= big;
            d1_sw_reg   <= c_tag.sw;
            d1_sh_reg   <= c_tag.sh;
            d1_lift_reg <= c_tag.lift;
        end
    end

    // ------------------------------------------------------------------
    // Stage d2: visibility, screen x numerator, squares
    // ------------------------------------------------------------------
    logic signed [DIFF_W:0] diff2;
    logic signed [DIFF_W:0] fov_s;
    logic signed [DIFF_W:0] t_sum;
    logic                   vis_now;
    logic [35:0]            sx_prod;

    always_comb
    begin
        diff2   = {d1_diff_reg, 1'b0};
        fov_s   = $signed({4'b0, fov_eff});
        vis_now = (diff2 >= -fov_s) && (diff2 <= fov_s);
        t_sum   = fov_s + diff2;
        // t_sum lies in [0, 2*fov] whenever the sprite is visible
        sx_prod = 36'({screen_width_reg, 8'b0}) * 36'(t_sum[15:0]);
    end

    logic               d2_valid_reg;
    logic               d2_vis_reg;
    logic [QUO_W-1:0]   d2_snum_reg;
    logic [15:0]        d2_sden_reg;
    logic [61:0]        d2_px_reg;
    logic [61:0]        d2_py_reg;
    logic               d2_shf_reg;
    logic [11:0]        d2_sw_reg;
    logic [11:0]        d2_sh_reg;
    logic signed [15:0] d2_lift_reg;

    always_ff @(posedge clk)
    begin
        if (en) begin
            d2_vis_reg  <= vis_now;
            d2_snum_reg <= QUO_W'(sx_prod) + QUO_W'(fov_eff);
            d2_sden_reg <= {fov_eff, 1'b0};
            d2_px_reg   <= 62'(d1_ax_reg) * 62'(d1_ax_reg);
            d2_py_reg   <= 62'(d1_ay_reg) * 62'(d1_ay_reg);
            d2_shf_reg  <= d1_shf_reg;
            d2_sw_reg   <= d1_sw_reg;
            d2_sh_reg   <= d1_sh_reg;
            d2_lift_reg <= d1_lift_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage d3: sum of squares
    // ------------------------------------------------------------------
    logic        d3_valid_reg;
    logic [62:0] d3_n_reg;
    stag_t       d3_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en) begin
            d3_n_reg        <= 63'(d2_px_reg) + 63'(d2_py_reg);
            d3_tag_reg.vis  <= d2_vis_reg;
            d3_tag_reg.snum <= d2_snum_reg;
            d3_tag_reg.sden <= d2_sden_reg;
            d3_tag_reg.shf  <= d2_shf_reg;
            d3_tag_reg.sw   <= d2_sw_reg;
            d3_tag_reg.sh   <= d2_sh_reg;
            d3_tag_reg.lift <= d2_lift_reg;
        end
    end

    // ------------------------------------------------------------------
    // Root extraction: one result bit per stage
    // ------------------------------------------------------------------
    logic [63:0]           sq_n_reg   [0:SQRT_STEPS-2];
    logic [63:0]           sq_r_reg   [0:SQRT_STEPS-1];
    stag_t                 sq_tag_reg [0:SQRT_STEPS-1];
    logic [SQRT_STEPS-1:0] sq_valid_reg;

    function automatic logic [127:0] sqrt_step(
        input logic [63:0] n,
        input logic [63:0] r,
        input logic [63:0] b
    );
        logic [63:0] rb;
        rb = r + b;
        if (n >= rb) begin
            return {n - rb, (r >> 1) + b};
        end
        return {n, r >> 1};
    endfunction

    always_ff @(posedge clk)
    begin
        if (en) begin
            {sq_n_reg[0], sq_r_reg[0]} <=
                sqrt_step({1'b0, d3_n_reg}, '0, 64'd1 << (2 * SQRT_STEPS - 2));
            sq_tag_reg[0] <= d3_tag_reg;
            for (int k = 1; k < SQRT_STEPS - 1; k++) begin
                {sq_n_reg[k], sq_r_reg[k]} <=
                    sqrt_step(sq_n_reg[k-1], sq_r_reg[k-1],
                              64'd1 << (2 * SQRT_STEPS - 2 - 2 * k));
                sq_tag_reg[k] <= sq_tag_reg[k-1];
            end
            sq_r_reg[SQRT_STEPS-1] <= 64'(sqrt_step(sq_n_reg[SQRT_STEPS-2],
                                                    sq_r_reg[SQRT_STEPS-2], 64'd1));
            sq_tag_reg[SQRT_STEPS-1] <= sq_tag_reg[SQRT_STEPS-2];
        end
    end

    // ------------------------------------------------------------------
    // Stage d4: distance and rounded numerators
    // ------------------------------------------------------------------
    stag_t                       sq_out;
    logic [DEN_W-1:0]            dist_q16;
    logic [DEN_W-2:0]            half_d;
    logic signed [16:0]          lift_ext;
    logic [16:0]                 lift_mag;

    always_comb
    begin
        sq_out   = sq_tag_reg[SQRT_STEPS-1];
        dist_q16 = sq_out.shf ? {sq_r_reg[SQRT_STEPS-1][31:0], 1'b0}
                              : {1'b0, sq_r_reg[SQRT_STEPS-1][31:0]};
        half_d   = dist_q16[DEN_W-1:1];
        lift_ext = 17'(sq_out.lift);
        lift_mag = lift_ext[16] ? 17'(-lift_ext) : 17'(lift_ext);
    end

    logic                        d4_valid_reg;
    logic [LANES-1:0][QUO_W-1:0] d4_num_reg;
    logic [LANES-1:0][DEN_W-1:0] d4_den_reg;
    dtag_t                       d4_tag_reg;

    always_ff @(posedge clk)
    begin
        if (en) begin
            d4_num_reg[LN_SX]   <= sq_out.snum;
            d4_num_reg[LN_W]    <= QUO_W'({sq_out.sw, 24'b0}) + QUO_W'(half_d);
            d4_num_reg[LN_H]    <= QUO_W'({sq_out.sh, 24'b0}) + QUO_W'(half_d);
            d4_num_reg[LN_HW]   <= QUO_W'({sq_out.sw, 23'b0}) + QUO_W'(half_d);
            d4_num_reg[LN_HH]   <= QUO_W'({sq_out.sh, 23'b0}) + QUO_W'(half_d);
            d4_num_reg[LN_LIFT] <= QUO_W'({lift_mag, 24'b0}) + QUO_W'(half_d);
            d4_den_reg[LN_SX]   <= DEN_W'(sq_out.sden);
            for (int l = 1; l < LANES; l++) begin
                d4_den_reg[l] <= dist_q16;
            end
            d4_tag_reg.vis      <= sq_out.vis;
            d4_tag_reg.zero     <= (dist_q16 == '0);
            d4_tag_reg.lift_neg <= lift_ext[16];
        end
    end

    // ------------------------------------------------------------------
    // Valid bits of the top-level stages
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            d3_valid_reg <= 1'b0;
            sq_valid_reg <= '0;
            d4_valid_reg <= 1'b0;
        end
        else if (en) begin
            d1_valid_reg <= c_valid;
            d2_valid_reg <= d1_valid_reg;
            d3_valid_reg <= d2_valid_reg;
            sq_valid_reg <= {sq_valid_reg[SQRT_STEPS-2:0], d3_valid_reg};
            d4_valid_reg <= sq_valid_reg[SQRT_STEPS-1];
        end
    end

    // ------------------------------------------------------------------
    // Division
    // ------------------------------------------------------------------
    logic                        q_valid;
    logic [LANES-1:0][QUO_W-1:0] q;
    dtag_t                       q_tag;

    bsp_div #(
        .LANES (LANES),
        .NUM_W (QUO_W),
        .DEN_W (DEN_W),
        .TAG_W ($bits(dtag_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d4_valid_reg),
        .in_num    (d4_num_reg),
        .in_den    (d4_den_reg),
        .in_tag    (d4_tag_reg),
        .out_valid (q_valid),
        .out_quo   (q),
        .out_tag   (q_tag)
    );

    // ------------------------------------------------------------------
    // Output stage: assemble rectangle, saturate, zero the rectangle of invisible sprites
    // ------------------------------------------------------------------
    logic signed [41:0] left_wide;
    logic signed [42:0] top_base;
    logic signed [42:0] top_wide;
    logic signed [31:0] left_next;
    logic signed [31:0] top_next;
    logic [30:0]        w_next;
    logic [30:0]        h_next;

    always_comb
    begin
        left_wide = $signed({2'b0, q[LN_SX]}) - $signed({2'b0, q[LN_HW]});
        top_base  = $signed(43'({screen_height_reg, 7'b0})) - $signed({3'b0, q[LN_HH]});
        top_wide  = q_tag.lift_neg ? top_base + $signed({3'b0, q[LN_LIFT]})
                                   : top_base - $signed({3'b0, q[LN_LIFT]});
        if (!q_tag.vis) begin
            left_next = '0;
            top_next  = '0;
            w_next    = '0;
            h_next    = '0;
        end
        else if (q_tag.zero) begin
            left_next = S32_MIN;
            top_next  = S32_MIN;
            w_next    = U31_MAX;
            h_next    = U31_MAX;
        end
        else begin
            if (left_wide > 42'(S32_MAX)) begin
                left_next = S32_MAX;
            end
            else if (left_wide < 42'(S32_MIN)) begin
                left_next = S32_MIN;
            end
            else begin
                left_next = left_wide[31:0];
            end
            if (top_wide > 43'(S32_MAX)) begin
                top_next = S32_MAX;
            end
            else if (top_wide < 43'(S32_MIN)) begin
                top_next = S32_MIN;
            end
            else begin
                top_next = top_wide[31:0];
            end
            w_next = (q[LN_W] > QUO_W'(U31_MAX)) ? U31_MAX : q[LN_W][30:0];
            h_next = (q[LN_H] > QUO_W'(U31_MAX)) ? U31_MAX : q[LN_H][30:0];
        end
    end

    logic               visible_reg;
    logic signed [31:0] rect_left_reg;
    logic signed [31:0] rect_top_reg;
    logic [30:0]        rect_w_reg;
    logic [30:0]        rect_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (en) begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            visible_reg   <= q_tag.vis;
            rect_left_reg <= left_next;
            rect_top_reg  <= top_next;
            rect_w_reg    <= w_next;
            rect_h_reg    <= h_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;
    assign rect_left = rect_left_reg;
    assign rect_top  = rect_top_reg;
    assign rect_w    = rect_w_reg;
    assign rect_h    = rect_h_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BSP_ASSERT(a_hidden_zero, (out_valid_reg && !visible_reg) |-> ((rect_left_reg == '0) && (rect_top_reg == '0) && (rect_w_reg == '0) && (rect_h_reg == '0)), "hidden sprite with nonzero rectangle")
    `BSP_ASSERT(a_ready_when_empty, !out_valid_reg |-> in_ready, "input stalled with empty output register")
    `BSP_ASSERT(a_reset_clears, $past(!rst_n) |-> (!out_valid_reg && !p0_valid_reg && !d4_valid_reg), "valid bit set right after reset")
    `BSP_ASSERT_NEVER(a_held_on_stall, $past(out_valid_reg && !out_ready) && !out_valid_reg, "output beat lost during stall")

endmodule
